// ===== src/idct_pkg.sv =====
// Shared constants, types and basis-weight functions for the direct 8x8 inverse DCT.
package idct_pkg;

	localparam int WEIGHT_FRAC_BITS = 15;
	localparam int ROM_FRAC_BITS    = 30;
	localparam int COEF_W           = 16;
	localparam int SAMPLE_W         = 16;
	localparam int BASIS_W          = ROM_FRAC_BITS + 1;
	localparam int PROD_W           = 2 * BASIS_W;
	localparam int WEIGHT_W         = WEIGHT_FRAC_BITS;
	localparam int MAC_W            = COEF_W + WEIGHT_W;
	localparam int ACC_W            = 40;
	localparam int RND_SHIFT        = 2 * ROM_FRAC_BITS - WEIGHT_FRAC_BITS;
	localparam int BLOCK_N          = 64;
	localparam int IDX_W            = 6;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_N - 1);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Controller states, one-hot
	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic             ram_we;
		logic [IDX_W-1:0] ram_waddr;
		logic             issue;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] k;
		logic             emit;
		logic             block_end;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic done;
		logic out_free;
	} status_t;

	// Q1.30 cos(m pi/16) / 2 for m = 0..8
	function automatic logic signed [BASIS_W-1:0] half_cos(input logic [3:0] m);
		logic signed [BASIS_W-1:0] r;
		unique case (m)
			4'd0:    r = BASIS_W'(536870912);
			4'd1:    r = BASIS_W'(526555088);
			4'd2:    r = BASIS_W'(496004047);
			4'd3:    r = BASIS_W'(446391849);
			4'd4:    r = BASIS_W'(379625062);
			4'd5:    r = BASIS_W'(298269498);
			4'd6:    r = BASIS_W'(205451603);
			4'd7:    r = BASIS_W'(104738319);
			default: r = '0;
		endcase
		return r;
	endfunction

	// 1-D weight c(k)/2 cos((2n+1)k pi/16) in Q1.30
	function automatic logic signed [BASIS_W-1:0] basis(input logic [2:0] n,
			input logic [2:0] k);
		logic [6:0] p;
		logic [4:0] m;
		logic signed [BASIS_W-1:0] r;
		p = {3'b000, n, 1'b1} * {4'b0000, k};
		m = p[4:0];
		if (m > 5'd16) begin
			m = 5'(6'd32 - {1'b0, m});
		end
		if (k == 3'd0) begin
			r = half_cos(4'd4);
		end else if (m > 5'd8) begin
			r = -half_cos(4'(5'd16 - m));
		end else begin
			r = half_cos(m[3:0]);
		end
		return r;
	endfunction

endpackage

// ===== src/idct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module idct_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/idct_ctrl.sv =====
// Sequencer for loading, MAC issue, drain and sample emission.
module idct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  idct_pkg::status_t status,
	output idct_pkg::cmd_t   cmd
);
	import idct_pkg::*;

	state_t            state_q;
	logic [IDX_W-1:0]  load_cnt_q;
	logic [IDX_W-1:0]  k_q;
	logic [IDX_W-1:0]  n_q;
	logic              in_acc;

	assign s_tready = (state_q == S_LOAD);
	assign in_acc   = s_tvalid && s_tready;

	// Drive datapath commands
	always_comb begin
		cmd           = '0;
		cmd.ram_we    = in_acc;
		cmd.ram_waddr = load_cnt_q;
		cmd.issue     = (state_q == S_ISSUE);
		cmd.first     = (k_q == '0);
		cmd.last      = (k_q == IDX_LAST);
		cmd.n         = n_q;
		cmd.k         = k_q;
		cmd.emit      = (state_q == S_EMIT) && status.out_free;
		cmd.block_end = (n_q == IDX_LAST);
	end

	// Advance state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_LOAD;
			load_cnt_q <= '0;
			k_q        <= '0;
			n_q        <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						load_cnt_q <= load_cnt_q + 1'b1;
						if (load_cnt_q == IDX_LAST) begin
							k_q     <= '0;
							n_q     <= '0;
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					k_q <= k_q + 1'b1;
					if (k_q == IDX_LAST) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (status.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (status.out_free) begin
						k_q <= '0;
						n_q <= n_q + 1'b1;
						if (n_q == IDX_LAST) begin
							state_q <= S_LOAD;
						end else begin
							state_q <= S_ISSUE;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ===== src/idct_dp.sv =====
// Coefficient store, weight pipeline, MAC with saturating accumulator, output register.
module idct_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  idct_pkg::cmd_t                    cmd,
	input  logic [idct_pkg::COEF_W-1:0]       coefficient,
	output idct_pkg::status_t                 status,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [idct_pkg::SAMPLE_W-1:0]     m_tdata,
	output logic                              m_tlast
);
	import idct_pkg::*;

	logic [COEF_W-1:0]          rdata;
	logic                       vld_s1, vld_s2, vld_s3, vld_s4;
	logic                       first_s1, first_s2, first_s3, first_s4;
	logic                       last_s1, last_s2, last_s3, last_s4;
	logic signed [BASIS_W-1:0]  a_s1, b_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [COEF_W-1:0]   coef_s2, coef_s3;
	logic signed [WEIGHT_W-1:0] weight_s3;
	logic signed [MAC_W-1:0]    mac_s4;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       done_q;
	logic                       out_vld_q;
	logic [SAMPLE_W-1:0]        sample_q;
	logic                       last_q;

	logic                       p_neg;
	logic [PROD_W-1:0]          p_mag;
	logic [PROD_W-1:0]          p_rsum;
	logic [WEIGHT_W-1:0]        w_mag;
	logic signed [WEIGHT_W-1:0] weight_d;
	logic signed [ACC_W:0]      acc_sum;
	logic signed [ACC_W-1:0]    acc_d;
	logic                       a_neg;
	logic [ACC_W-1:0]           a_mag;
	logic [ACC_W-1:0]           a_shr;
	logic [SAMPLE_W-1:0]        sample_d;

	idct_ram #(
		.WIDTH (COEF_W),
		.DEPTH (BLOCK_N)
	) u_store (
		.clk   (clk),
		.we    (cmd.ram_we),
		.waddr (cmd.ram_waddr),
		.wdata (coefficient),
		.raddr (cmd.k),
		.rdata (rdata)
	);

	// Stage 1: look up both 1-D weights
	always_ff @(posedge clk) begin
		a_s1 <= basis(cmd.n[2:0], cmd.k[2:0]);
		b_s1 <= basis(cmd.n[5:3], cmd.k[5:3]);
	end

	// Stage 2: combined weight product, latch coefficient
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		coef_s2 <= rdata;
	end

	// Round product half away from zero
	always_comb begin
		p_neg    = prod_s2[PROD_W-1];
		p_mag    = p_neg ? PROD_W'(-prod_s2) : PROD_W'(prod_s2);
		p_rsum   = p_mag + (PROD_W'(1) << (RND_SHIFT - 1));
		w_mag    = WEIGHT_W'(p_rsum >> RND_SHIFT);
		weight_d = p_neg ? -w_mag : w_mag;
	end

	// Stage 3: hold rounded weight and coefficient
	always_ff @(posedge clk) begin
		weight_s3 <= weight_d;
		coef_s3   <= coef_s2;
	end

	// Stage 4: coefficient times weight
	always_ff @(posedge clk) begin
		mac_s4 <= coef_s3 * weight_s3;
	end

	// Saturating accumulate, restart on first term
	always_comb begin
		acc_sum = first_s4 ? (ACC_W+1)'(mac_s4)
		                   : (ACC_W+1)'(mac_s4) + (ACC_W+1)'(acc_q);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_d = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_d = acc_sum[ACC_W-1:0];
		end
	end

	// Pipeline control bits, accumulator and done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			first_s1 <= 1'b0;
			first_s2 <= 1'b0;
			first_s3 <= 1'b0;
			first_s4 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
			last_s4  <= 1'b0;
			acc_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			vld_s1   <= cmd.issue;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= vld_s3;
			first_s1 <= cmd.first;
			first_s2 <= first_s1;
			first_s3 <= first_s2;
			first_s4 <= first_s3;
			last_s1  <= cmd.last;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
			last_s4  <= last_s3;
			if (vld_s4) begin
				acc_q <= acc_d;
			end
			done_q <= vld_s4 && last_s4;
		end
	end

	// Drop fraction toward zero and clamp to sample range
	always_comb begin
		a_neg = acc_q[ACC_W-1];
		a_mag = a_neg ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		a_shr = a_mag >> WEIGHT_FRAC_BITS;
		if (!a_neg) begin
			sample_d = (a_shr > ACC_W'(SAMPLE_MAX)) ? SAMPLE_MAX : a_shr[SAMPLE_W-1:0];
		end else begin
			sample_d = (a_shr > ACC_W'(-32'(SAMPLE_MIN))) ? SAMPLE_MIN
			                                              : -a_shr[SAMPLE_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sample_q <= sample_d;
			last_q   <= cmd.block_end;
		end
	end

	assign status.done     = done_q;
	assign status.out_free = !out_vld_q || m_tready;
	assign m_tvalid        = out_vld_q;
	assign m_tdata         = sample_q;
	assign m_tlast         = last_q;

endmodule

// ===== src/direct_idct_8x8.sv =====
// Top level of the direct 8x8 inverse DCT: controller, datapath and checks.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata[15:0] coefficient
// m_*      out  m_tvalid/m_tready  m_tdata[15:0] sample, m_tlast block_end
//
// Sequence: 64 items load one per cycle while s_tvalid is high; each sample then
// issues one MAC term per coefficient on the single shared MAC multiplier, drains
// through the weight, product, MAC and accumulator registers and is then emitted.
// Reset: arst_n clears control state; the coefficient store holds no reset value.
// Stalls: a low m_tready keeps a sample waiting in the output register; the
// sequencer holds in emit until that register frees, which delays the next sample.
// s_tready is high only while a block is being loaded.
module direct_idct_8x8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] coefficient
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] sample
	output logic        m_tlast
);
	import idct_pkg::*;

	cmd_t    cmd;
	status_t status;

	idct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	idct_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.coefficient (s_tdata),
		.status      (status),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

	// No coefficient is loaded while MACs are issued
	a_no_load_in_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !cmd.issue)
		else $error("coefficient accepted during MAC issue");

	// Accumulation finishes only after issue has stopped
	a_done_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> !cmd.issue)
		else $error("accumulation done while still issuing");

	// A pending sample is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

endmodule

// ===== verif/idct_checker.sv =====
// Checker for the direct 8x8 inverse DCT: predicts each block's samples and compares them.
`timescale 1ns / 1ps
module idct_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] coefficient
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [15:0] sample
	input  logic        m_tlast,   // block_end
	output int          error_count,
	output int          pending_count,
	output int          sample_count,
	output int          limit_count
);

	localparam int  SHIFT     = 2 * idct_pkg::ROM_FRAC_BITS - idct_pkg::WEIGHT_FRAC_BITS;
	localparam longint ACC_TOP = (longint'(1) <<< (idct_pkg::ACC_W - 1)) - 1;
	localparam longint ACC_BOT = -ACC_TOP - 1;

	typedef struct {
		logic signed [15:0] sample;
		logic               block_end;
	} idct_sample_t;

	logic signed [15:0] coef_store [idct_pkg::BLOCK_N];
	idct_sample_t       expected_samples [$];
	int                 load_index;
	int                 errors;
	int                 checked;
	int                 at_limit;

	// cos(m pi/16) / 2 in Q1.30
	function automatic longint half_cos_q30(input int m);
		case (m)
			0:       return 536870912;
			1:       return 526555088;
			2:       return 496004047;
			3:       return 446391849;
			4:       return 379625062;
			5:       return 298269498;
			6:       return 205451603;
			7:       return 104738319;
			default: return 0;
		endcase
	endfunction

	// c(k)/2 cos((2n+1)k pi/16) in Q1.30, folded onto the first quarter wave
	function automatic longint basis_q30(input int n, input int k);
		int m;
		if (k == 0)
			return half_cos_q30(4);
		m = ((2 * n + 1) * k) % 32;
		if (m > 16)
			m = 32 - m;
		if (m > 8)
			return -half_cos_q30(16 - m);
		return half_cos_q30(m);
	endfunction

	// 2-D weight, rounded half away from zero to the weight's fraction bits
	function automatic longint combined_weight(input int x, input int y, input int u,
			input int v);
		longint prod;
		longint mag;
		longint rounded;
		prod    = basis_q30(x, u) * basis_q30(y, v);
		mag     = (prod < 0) ? -prod : prod;
		rounded = (mag + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
		return (prod < 0) ? -rounded : rounded;
	endfunction

	// Truncate toward zero, then clamp to int16
	function automatic logic signed [15:0] to_sample(input longint acc);
		longint mag;
		longint q;
		mag = (acc < 0) ? -acc : acc;
		mag = mag >>> idct_pkg::WEIGHT_FRAC_BITS;
		q   = (acc < 0) ? -mag : mag;
		if (q > 32767)
			return 16'sh7FFF;
		if (q < -32768)
			return 16'sh8000;
		return q[15:0];
	endfunction

	// Evaluate all 64 samples of the stored block in row-major order
	task automatic predict_block();
		longint       acc;
		idct_sample_t s;
		for (int y = 0; y < 8; y++) begin
			for (int x = 0; x < 8; x++) begin
				acc = 0;
				for (int v = 0; v < 8; v++) begin
					for (int u = 0; u < 8; u++) begin
						acc = acc + longint'(coef_store[v * 8 + u]) * combined_weight(x, y, u, v);
						if (acc > ACC_TOP)
							acc = ACC_TOP;
						else if (acc < ACC_BOT)
							acc = ACC_BOT;
					end
				end
				s.sample    = to_sample(acc);
				s.block_end = (y == 7 && x == 7);
				if (s.sample == 16'sh7FFF || s.sample == 16'sh8000)
					at_limit++;
				expected_samples.push_back(s);
			end
		end
	endtask

	initial begin
		load_index = 0;
		errors     = 0;
		checked    = 0;
		at_limit   = 0;
	end

	// Check each sample item against the oldest prediction, then absorb coefficients
	always @(posedge clk) begin
		idct_sample_t want;
		if (!arst_n) begin
			load_index = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				checked++;
				if (expected_samples.size() == 0) begin
					errors++;
					$error("sample %0d arrived with no expectation waiting", $signed(m_tdata));
				end else begin
					want = expected_samples.pop_front();
					if ($signed(m_tdata) !== want.sample) begin
						errors++;
						$error("sample: expected %0d, actual %0d", want.sample, $signed(m_tdata));
					end
					if (m_tlast !== want.block_end) begin
						errors++;
						$error("block_end: expected %0d, actual %0d", want.block_end, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				coef_store[load_index] = s_tdata;
				if (load_index == idct_pkg::BLOCK_N - 1) begin
					predict_block();
					load_index = 0;
				end else begin
					load_index++;
				end
			end
		end
		error_count   <= errors;
		pending_count <= expected_samples.size();
		sample_count  <= checked;
		limit_count   <= at_limit;
	end

endmodule

// ===== verif/direct_idct_8x8_tb.sv =====
// Testbench top for the direct 8x8 inverse DCT: stimulus, output stalls and verdict.
`timescale 1ns / 1ps
module direct_idct_8x8_tb;

	localparam int BLOCKS = 2;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	int          error_count;
	int          pending_count;
	int          sample_count;
	int          limit_count;
	int          sent;

	direct_idct_8x8 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	idct_checker sample_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.error_count   (error_count),
		.pending_count (pending_count),
		.sample_count  (sample_count),
		.limit_count   (limit_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short idle stretches, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one coefficient item after an optional gap and hold it until taken
	task automatic send_coefficient(input logic [15:0] value, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Stall the sample side in random bursts, with occasional long free runs
	initial begin
		int run;
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
			stall = idle_length();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Reset, feed the blocks, drain and give the verdict
	initial begin
		logic [15:0] value;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		sent     = 0;
		arst_n   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int blk = 0; blk < BLOCKS; blk++) begin
			for (int idx = 0; idx < idct_pkg::BLOCK_N; idx++) begin
				if (blk == 0) begin
					// open with the coefficient extremes and alternating bit patterns
					case (idx)
						0:       value = 16'h7FFF;
						1:       value = 16'h8000;
						2:       value = 16'h0000;
						3:       value = 16'hFFFF;
						4:       value = 16'h0001;
						5:       value = 16'h5555;
						6:       value = 16'hAAAA;
						7:       value = 16'h8001;
						8:       value = 16'h7FFE;
						9:       value = 16'h0100;
						10:      value = 16'hFF00;
						default: value = 16'($urandom_range(0, 16'hFFFF));
					endcase
				end else if (idx % 2 == 1) begin
					// large odd horizontal terms drive samples into both int16 limits
					value = 16'($urandom_range(16384, 32767));
				end else begin
					value = 16'($signed($urandom_range(0, 128)) - 64);
				end
				send_coefficient(value, idle_length());
			end
			// hold off until the whole block has come out
			s_tvalid <= 1'b0;
			@(posedge clk);
			while (pending_count != 0) @(posedge clk);
		end
		repeat (100) @(posedge clk);
		$display("Sent %0d coefficients in %0d blocks; checked %0d samples,",
			sent, BLOCKS, sample_count);
		$display("%0d of them at the int16 limits.", limit_count);
		if (error_count == 0 && pending_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
